>>> design/cbe_pkg.sv
// Shared types and constants for the confinement barrier energy block.
package cbe_pkg;

  localparam int SPECIES_TYPES = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] KIND_HARD     = 2'd0;
  localparam logic [1:0] KIND_SQW_SLIT = 2'd1;
  localparam logic [1:0] KIND_CYL      = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [35:0] ENERGY_MIN = {1'b1, 35'b0};

  typedef struct packed {
    logic               command;
    logic [3:0]         slot;
    logic [1:0]         kind;
    logic [3:0]         species;
    logic [1:0]         axis;
    logic signed [31:0] bound_hi;
    logic signed [31:0] bound_lo;
    logic [30:0]        well_depth;
    logic [30:0]        band_width;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } req_t;

  typedef struct packed {
    logic signed [35:0] energy;
    logic               energy_infinite;
    logic               inside_any;
    logic               species_assigned;
  } rsp_t;

  // One feature slot as held in a cell, with the derived bounds worked out on write.
  typedef struct packed {
    logic [3:0]         species;
    logic [1:0]         axis;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [32:0] hi_band;
    logic signed [32:0] lo_band;
    logic [30:0]        depth;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               r_pos;
    logic [61:0]        r_sq;
    logic               inner_pos;
    logic [61:0]        inner_sq;
  } feat_t;

  // Running sums carried from cell to cell.
  typedef struct packed {
    logic               valid;
    logic signed [35:0] energy;
    logic               inf;
    logic               contained;
    logic               assigned;
  } tok_t;

endpackage

>>> design/cbe_cell.sv
// One feature slot: its stored feature, local geometry pipeline and sum stage.
module cbe_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_kind,
  input  cbe_pkg::feat_t     wr_feat,
  input  logic [3:0]         sel_species,
  input  logic signed [31:0] pt_x,
  input  logic signed [31:0] pt_y,
  input  logic signed [31:0] pt_z,
  input  cbe_pkg::tok_t      tok_in,
  output cbe_pkg::tok_t      tok_out
);
  import cbe_pkg::*;

  function automatic logic [31:0] magnitude(input logic signed [32:0] d);
    logic signed [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  logic [1:0]         kind;
  feat_t              f;

  logic signed [31:0] c;
  logic signed [32:0] c_ext;
  logic signed [32:0] dx, dy, dz, d0, d1;

  logic               match_q;
  logic               gt_lo, lt_hi, gt_hb, lt_lb;
  logic [31:0]        m0, m1;
  logic [63:0]        sq0, sq1;
  logic [64:0]        sq_sum;
  logic               cyl_in, cyl_inner;

  logic               in_f, well, hit;
  logic signed [36:0] diff;
  logic signed [35:0] energy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_UNUSED;
    end else if (wr_en) begin
      kind <= wr_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      f <= wr_feat;
    end
  end

  always_comb begin
    case (f.axis)
      AXIS_X:  c = pt_x;
      AXIS_Y:  c = pt_y;
      default: c = pt_z;
    endcase
  end

  assign c_ext = {c[31], c};
  assign dx = {pt_x[31], pt_x} - {f.px[31], f.px};
  assign dy = {pt_y[31], pt_y} - {f.py[31], f.py};
  assign dz = {pt_z[31], pt_z} - {f.pz[31], f.pz};
  assign d0 = (f.axis == AXIS_X) ? dy : dx;
  assign d1 = (f.axis == AXIS_Z) ? dy : dz;

  // The point is held for the whole evaluation, so each stage settles once and stays.
  always_ff @(posedge clk) begin
    match_q <= (kind != KIND_UNUSED) && (f.species == sel_species);
    gt_lo   <= c > f.lo;
    lt_hi   <= c < f.hi;
    gt_hb   <= c_ext > f.hi_band;
    lt_lb   <= c_ext < f.lo_band;
    m0      <= magnitude(d0);
    m1      <= magnitude(d1);
    sq0     <= 64'(m0) * 64'(m0);
    sq1     <= 64'(m1) * 64'(m1);
    cyl_in    <= f.r_pos && (sq_sum < {3'b0, f.r_sq});
    cyl_inner <= f.inner_pos && (sq_sum < {3'b0, f.inner_sq});
  end

  assign sq_sum = {1'b0, sq0} + {1'b0, sq1};

  always_comb begin
    if (kind == KIND_CYL) begin
      in_f = cyl_in;
      well = !cyl_inner;
    end else begin
      in_f = gt_lo && lt_hi;
      well = (kind == KIND_SQW_SLIT) && (gt_hb || lt_lb);
    end
  end

  assign hit  = match_q && in_f && well;
  assign diff = {tok_in.energy[35], tok_in.energy} - {6'b0, f.depth};

  // The sum cannot fall more than one depth below the floor, so two top bits tell overflow.
  always_comb begin
    if (!hit) begin
      energy_next = tok_in.energy;
    end else if (diff[36:35] == 2'b10) begin
      energy_next = ENERGY_MIN;
    end else begin
      energy_next = diff[35:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.energy    <= energy_next;
    tok_out.inf       <= tok_in.inf || (match_q && !in_f);
    tok_out.contained <= tok_in.contained || (match_q && in_f);
    tok_out.assigned  <= tok_in.assigned || match_q;
  end

endmodule

>>> design/confinement_barrier_energy.sv
// Top level of the confinement barrier energy block: control, write path and cell chain.
// One item is worked on at a time; a new item is accepted only once the last one is through.
// A write item stores its feature in the write state. An evaluate item first waits in the fill
// state while the per-cell distance (m0/m1), squaring (sq0/sq1) and compare registers settle,
// then the running sum walks the row of MAX_FEATURES cells one cell per cycle, and the
// finished sum moves through the pend register into the output register. A waiting result in
// the output register does not keep the block from accepting the next item; the block waits
// only when a new result is finished while the previous one is still not taken.
module confinement_barrier_energy #(
  parameter int MAX_FEATURES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cbe_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cbe_pkg::rsp_t  rsp
);
  import cbe_pkg::*;

  localparam logic [1:0] FILL_LAST = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_FILL,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t             state;
  req_t               held;
  logic [1:0]         cnt;
  rsp_t               pend;

  logic               species_ok;
  logic               launch;
  logic signed [31:0] r;
  logic signed [32:0] inner;
  feat_t              wr_feat;
  tok_t               tok [0:MAX_FEATURES];

  assign req_stall = (state != S_IDLE);

  // Derived bounds for the slot being written.
  assign r     = held.bound_hi;
  assign inner = {r[31], r} - {2'b0, held.band_width};

  always_comb begin
    wr_feat.species   = held.species;
    wr_feat.axis      = (held.axis inside {AXIS_X, AXIS_Y}) ? held.axis : AXIS_Z;
    wr_feat.hi        = held.bound_hi;
    wr_feat.lo        = held.bound_lo;
    wr_feat.hi_band   = {held.bound_hi[31], held.bound_hi} - {2'b0, held.band_width};
    wr_feat.lo_band   = {held.bound_lo[31], held.bound_lo} + {2'b0, held.band_width};
    wr_feat.depth     = held.well_depth;
    wr_feat.px        = held.coord_x;
    wr_feat.py        = held.coord_y;
    wr_feat.pz        = held.coord_z;
    wr_feat.r_pos     = !r[31] && (r != 32'sd0);
    wr_feat.r_sq      = 62'(r[30:0]) * 62'(r[30:0]);
    wr_feat.inner_pos = !inner[32] && (inner != 33'sd0);
    wr_feat.inner_sq  = 62'(inner[30:0]) * 62'(inner[30:0]);
  end

  assign species_ok = (32'(held.species) < SPECIES_TYPES);
  assign launch     = (state == S_FILL) && (cnt == FILL_LAST);

  always_comb begin
    tok[0].valid     = launch;
    tok[0].energy    = '0;
    tok[0].inf       = 1'b0;
    tok[0].contained = 1'b0;
    tok[0].assigned  = 1'b0;
  end

  for (genvar i = 0; i < MAX_FEATURES; i++) begin : g_cell
    logic wr_en;
    assign wr_en = (state == S_WRITE) && species_ok && (32'(held.slot) == i);

    cbe_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .wr_en       (wr_en),
      .wr_kind     (held.kind),
      .wr_feat     (wr_feat),
      .sel_species (held.species),
      .pt_x        (held.coord_x),
      .pt_y        (held.coord_y),
      .pt_z        (held.coord_z),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DRAIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            held <= req;
            cnt  <= '0;
            state <= (req.command == CMD_EVAL) ? S_FILL : S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_FILL: begin
          cnt <= cnt + 2'd1;
          if (cnt == FILL_LAST) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok[MAX_FEATURES].valid) begin
            pend.energy           <= tok[MAX_FEATURES].energy;
            pend.energy_infinite  <= tok[MAX_FEATURES].inf;
            pend.inside_any       <= tok[MAX_FEATURES].contained ||
                                     !tok[MAX_FEATURES].assigned;
            pend.species_assigned <= tok[MAX_FEATURES].assigned;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= pend;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/cbe_checker.sv
// Port-level checks for the confinement barrier energy block, bound to the top level.
module cbe_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input cbe_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input cbe_pkg::rsp_t rsp
);
  import cbe_pkg::*;

  // A result that is not taken stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // The block works on one item at a time, so an accepted item stalls the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input not stalled after an accepted item");

  // A species without features sees no energy and counts as inside.
  a_unassigned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.species_assigned |->
      rsp.energy == 36'sd0 && !rsp.energy_infinite && rsp.inside_any)
    else $error("unassigned species gave a nonzero result");

  // Only wells contribute, so the energy sum is never positive.
  a_energy_sign: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.energy[35] || rsp.energy == 36'sd0)
    else $error("positive energy reported");

endmodule

bind confinement_barrier_energy cbe_checker u_cbe_checker (.*);
